### rtl/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg: shared types and constants for the opcode length table framer
// Field widths, register indexes, result kinds and the structs that pass
// configuration and decode status between modules.
// ----------------------------------------------------------------------------
package olt_pkg;

  localparam int BYTE_W         = 8;
  localparam int LEN_W          = 4;
  localparam int PAY_W          = 64;
  localparam int LANES          = PAY_W / BYTE_W;
  localparam int LANE_IDX_W     = $clog2(LANES);
  localparam int NUM_ENTRY_REGS = 6;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 13;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCONNECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY0     = 3'd2;

  localparam logic [BYTE_W-1:0] REFRESH_RST    = 8'd254;
  localparam logic [BYTE_W-1:0] DISCONNECT_RST = 8'd253;

  typedef enum logic [1:0] {
    KIND_INSTR      = 2'd0,
    KIND_REFRESH    = 2'd1,
    KIND_DISCONNECT = 2'd2
  } olt_kind_t;

  // same bit layout as the table register: valid, opcode, length
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] opcode;
    logic [LEN_W-1:0]  len;
  } olt_entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0]                  refresh_code;
    logic [BYTE_W-1:0]                  disconnect_code;
    olt_entry_t [NUM_ENTRY_REGS-1:0]    entries;
  } olt_cfg_t;

  typedef struct packed {
    logic             refresh;
    logic             disconnect;
    logic             hit;
    logic [LEN_W-1:0] len;
  } olt_dec_t;

endpackage

### rtl/olt_byte_if.sv
// ----------------------------------------------------------------------------
// olt_byte_if: received byte channel
// Valid/ready channel carrying one link byte per transfer.
// ----------------------------------------------------------------------------
interface olt_byte_if;
  logic                        valid;
  logic                        ready;
  logic [olt_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

### rtl/olt_result_if.sv
// ----------------------------------------------------------------------------
// olt_result_if: framer result channel
// Valid/ready channel carrying one event or completed instruction.
// ----------------------------------------------------------------------------
interface olt_result_if;
  logic                        valid;
  logic                        ready;
  olt_pkg::olt_kind_t          kind;
  logic [olt_pkg::BYTE_W-1:0]  opcode;
  logic [olt_pkg::LEN_W-1:0]   payload_len;
  logic [olt_pkg::PAY_W-1:0]   payload;

  modport source (output valid, output kind, output opcode, output payload_len,
                  output payload, input ready);
  modport sink   (input valid, input kind, input opcode, input payload_len,
                  input payload, output ready);
endinterface

### rtl/olt_cfg_regs.sv
// ----------------------------------------------------------------------------
// olt_cfg_regs: configuration register file
// Event codes and opcode table entries, written through a plain write port.
// ----------------------------------------------------------------------------
module olt_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [olt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [olt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output olt_pkg::olt_cfg_t                cfg
);
  import olt_pkg::*;

  olt_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.refresh_code    <= REFRESH_RST;
      cfg_r.disconnect_code <= DISCONNECT_RST;
      cfg_r.entries         <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_REFRESH) begin
        cfg_r.refresh_code <= cfg_wdata[BYTE_W-1:0];
      end
      if (cfg_index == REG_DISCONNECT) begin
        cfg_r.disconnect_code <= cfg_wdata[BYTE_W-1:0];
      end
      for (int i = 0; i < NUM_ENTRY_REGS; i++) begin
        if (cfg_index == CFG_IDX_W'(REG_ENTRY0 + i)) begin
          cfg_r.entries[i] <= cfg_wdata;
        end
      end
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/olt_match.sv
// ----------------------------------------------------------------------------
// olt_match: idle byte decoder
// Compares a byte against the event codes and the opcode table in parallel.
// ----------------------------------------------------------------------------
module olt_match #(
  parameter int MAX_PAYLOAD   = 8,
  parameter int TABLE_ENTRIES = 6
) (
  input  logic [olt_pkg::BYTE_W-1:0]  data_byte,
  input  olt_pkg::olt_cfg_t           cfg,
  output olt_pkg::olt_dec_t           dec
);
  import olt_pkg::*;

  logic             hit;
  logic [LEN_W-1:0] raw_len;

  // descending scan so the lowest matching entry wins
  always_comb begin
    hit     = 1'b0;
    raw_len = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (cfg.entries[i].valid && cfg.entries[i].opcode == data_byte) begin
        hit     = 1'b1;
        raw_len = cfg.entries[i].len;
      end
    end
  end

  always_comb begin
    dec.refresh    = (data_byte == cfg.refresh_code);
    dec.disconnect = (data_byte == cfg.disconnect_code);
    dec.hit        = hit;
    dec.len        = (raw_len > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : raw_len;
  end

endmodule

### rtl/opcode_length_table_framer.sv
// ----------------------------------------------------------------------------
// opcode_length_table_framer: link byte framer with a configurable opcode table
// Turns a byte stream into event results and framed instructions.
// ----------------------------------------------------------------------------
// Usage:
//   in_byte carries one received byte per transfer. out_result carries
//   refresh/disconnect events and completed instructions (opcode, length,
//   payload with the first byte in bits 7:0). Bytes that cause no result
//   (unknown opcodes, opcodes that open a payload, payload bytes before the last) give no transfer.
//   The cfg_ port writes the event codes and the six table entries; write
//   only while no byte is in flight.
//   Path: the byte that completes a result passes through the input
//   register, then the result register.
//   Throughput: one byte per cycle while in_byte.ready is high; the single
//   pass through the event compare, table compare and lane merge sets that figure.
//   When the receiver stalls, a result waits in the result register while
//   bytes that cause no result keep flowing; in_byte.ready drops only when
//   a byte that would give a result meets a full result register.
//   Reset (rst_n low, synchronous) empties both registers, returns the
//   framer to idle and loads the register reset values.
// ----------------------------------------------------------------------------
module opcode_length_table_framer #(
  parameter int MAX_PAYLOAD   = 8,
  parameter int TABLE_ENTRIES = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  olt_byte_if.sink                         in_byte,
  olt_result_if.source                     out_result,
  input  logic                             cfg_we,
  input  logic [olt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [olt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import olt_pkg::*;

  olt_cfg_t cfg;
  olt_dec_t dec;

  // input register
  logic              in_q_valid_r;
  logic [BYTE_W-1:0] in_q_byte_r;

  // framing state
  logic              collecting_r,  collecting_nxt;
  logic [BYTE_W-1:0] cur_opcode_r,  cur_opcode_nxt;
  logic [LEN_W-1:0]  needed_r,      needed_nxt;
  logic [LEN_W-1:0]  remaining_r,   remaining_nxt;
  logic [PAY_W-1:0]  store_r,       store_nxt;

  // result register
  logic              out_valid_r;
  olt_kind_t         out_kind_r;
  logic [BYTE_W-1:0] out_opcode_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [PAY_W-1:0]  out_payload_r;

  logic              emit;
  olt_kind_t         res_kind;
  logic [BYTE_W-1:0] res_opcode;
  logic [LEN_W-1:0]  res_len;
  logic [PAY_W-1:0]  res_payload;
  logic [LEN_W-1:0]  rem_dec;
  logic [LANE_IDX_W-1:0] pos;
  logic              out_free;
  logic              proc_fire;
  logic              in_ready;

  olt_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  olt_match #(
    .MAX_PAYLOAD   (MAX_PAYLOAD),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_match (
    .data_byte (in_q_byte_r),
    .cfg       (cfg),
    .dec       (dec)
  );

  always_comb begin
    emit           = 1'b0;
    res_kind       = KIND_INSTR;
    res_opcode     = '0;
    res_len        = '0;
    res_payload    = '0;
    collecting_nxt = collecting_r;
    cur_opcode_nxt = cur_opcode_r;
    needed_nxt     = needed_r;
    remaining_nxt  = remaining_r;
    store_nxt      = store_r;
    rem_dec        = remaining_r - LEN_W'(1);
    pos            = LANE_IDX_W'(needed_r - remaining_r);

    if (!collecting_r) begin
      if (dec.refresh) begin
        emit     = 1'b1;
        res_kind = KIND_REFRESH;
      end else if (dec.disconnect) begin
        emit     = 1'b1;
        res_kind = KIND_DISCONNECT;
      end else if (dec.hit) begin
        if (dec.len == '0) begin
          emit       = 1'b1;
          res_opcode = in_q_byte_r;
        end else begin
          collecting_nxt = 1'b1;
          cur_opcode_nxt = in_q_byte_r;
          needed_nxt     = dec.len;
          remaining_nxt  = dec.len;
          store_nxt      = '0;
        end
      end
    end else begin
      for (int k = 0; k < MAX_PAYLOAD; k++) begin
        if (pos == LANE_IDX_W'(k)) begin
          store_nxt[k*BYTE_W +: BYTE_W] = store_r[k*BYTE_W +: BYTE_W] | in_q_byte_r;
        end
      end
      remaining_nxt = rem_dec;
      if (rem_dec == '0) begin
        emit           = 1'b1;
        res_opcode     = cur_opcode_r;
        res_len        = needed_r;
        res_payload    = store_nxt;
        collecting_nxt = 1'b0;
      end
    end
  end

  assign out_free  = !out_valid_r || out_result.ready;
  assign proc_fire = in_q_valid_r && (!emit || out_free);
  assign in_ready  = !in_q_valid_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
      collecting_r <= 1'b0;
      cur_opcode_r <= '0;
      needed_r     <= '0;
      remaining_r  <= '0;
      store_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_q_valid_r <= in_byte.valid;
      end
      if (proc_fire) begin
        collecting_r <= collecting_nxt;
        cur_opcode_r <= cur_opcode_nxt;
        needed_r     <= needed_nxt;
        remaining_r  <= remaining_nxt;
        store_r      <= store_nxt;
      end
      if (out_free) begin
        out_valid_r <= proc_fire && emit;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_byte.valid) begin
      in_q_byte_r <= in_byte.data_byte;
    end
    if (proc_fire && emit) begin
      out_kind_r    <= res_kind;
      out_opcode_r  <= res_opcode;
      out_len_r     <= res_len;
      out_payload_r <= res_payload;
    end
  end

  assign in_byte.ready          = in_ready;
  assign out_result.valid       = out_valid_r;
  assign out_result.kind        = out_kind_r;
  assign out_result.opcode      = out_opcode_r;
  assign out_result.payload_len = out_len_r;
  assign out_result.payload     = out_payload_r;

`ifndef SYNTHESIS
  a_remaining_range: assert property (@(posedge clk) disable iff (!rst_n)
    collecting_r |-> (remaining_r != '0 && remaining_r <= needed_r))
    else $error("remaining count out of range while collecting");

  a_needed_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    collecting_r |-> (needed_r <= LEN_W'(MAX_PAYLOAD)))
    else $error("needed count above payload limit");

  a_last_byte_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && collecting_r && remaining_r == LEN_W'(1))
      |=> (!collecting_r && out_valid_r && out_kind_r == KIND_INSTR))
    else $error("last payload byte did not complete the instruction");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_result.ready) |-> !(proc_fire && emit))
    else $error("pending result overwritten");
`endif

endmodule

### verif/opcode_length_table_framer_tb.sv
// ----------------------------------------------------------------------------
// opcode_length_table_framer_tb: self-checking bench for the byte framer
// Drives link bytes through valid/ready with random sender gaps and receiver
// stalls, predicts events and framed instructions from its own copy of the
// codes and opcode table, and checks every result transfer in order.
// ----------------------------------------------------------------------------
module opcode_length_table_framer_tb;
  import olt_pkg::*;

  localparam int MAX_PAYLOAD   = 8;
  localparam int TABLE_ENTRIES = 6;

  typedef struct packed {
    olt_kind_t         kind;
    logic [BYTE_W-1:0] opcode;
    logic [LEN_W-1:0]  payload_len;
    logic [PAY_W-1:0]  payload;
  } frame_result_t;

  // Predicts the framer and holds the results still owed by the block.
  class frame_scoreboard;
    logic [BYTE_W-1:0] refresh_code = REFRESH_RST;
    logic [BYTE_W-1:0] disconnect_code = DISCONNECT_RST;
    olt_entry_t        table_regs[NUM_ENTRY_REGS];
    bit                collecting;
    logic [BYTE_W-1:0] cur_opcode;
    logic [LEN_W-1:0]  needed;
    logic [LEN_W-1:0]  remaining;
    logic [PAY_W-1:0]  payload_acc;
    frame_result_t     owed[$];
    int                errors;

    function new();
      foreach (table_regs[i]) table_regs[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_REFRESH) refresh_code = val[BYTE_W-1:0];
      else if (idx == REG_DISCONNECT) disconnect_code = val[BYTE_W-1:0];
      else if (idx - REG_ENTRY0 < NUM_ENTRY_REGS) table_regs[idx - REG_ENTRY0] = val;
    endfunction

    function void push(olt_kind_t k, logic [BYTE_W-1:0] op, logic [LEN_W-1:0] len,
                       logic [PAY_W-1:0] pay);
      frame_result_t r;
      r.kind = k;
      r.opcode = op;
      r.payload_len = len;
      r.payload = pay;
      owed.push_back(r);
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      bit                    hit;
      logic [LEN_W-1:0]      len;
      logic [LANE_IDX_W-1:0] lane;
      if (!collecting) begin
        hit = 1'b0;
        len = '0;
        if (b == refresh_code) begin
          push(KIND_REFRESH, '0, '0, '0);
        end else if (b == disconnect_code) begin
          push(KIND_DISCONNECT, '0, '0, '0);
        end else begin
          // lowest-numbered valid match wins
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!hit && table_regs[i].valid && table_regs[i].opcode == b) begin
              hit = 1'b1;
              len = table_regs[i].len;
            end
          end
          if (hit) begin
            if (len > MAX_PAYLOAD) len = LEN_W'(MAX_PAYLOAD);
            if (len == 0) begin
              push(KIND_INSTR, b, '0, '0);
            end else begin
              collecting = 1'b1;
              cur_opcode = b;
              needed = len;
              remaining = len;
              payload_acc = '0;
            end
          end
        end
      end else begin
        lane = LANE_IDX_W'(needed - remaining);
        payload_acc[lane*BYTE_W +: BYTE_W] = b;
        remaining = remaining - 1'b1;
        if (remaining == 0) begin
          push(KIND_INSTR, cur_opcode, needed, payload_acc);
          collecting = 1'b0;
        end
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (owed.size() == 0) begin
        $error("result transfer with nothing owed: kind %0d opcode %0h", got.kind, got.opcode);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.opcode !== want.opcode) begin
        $error("opcode: expected %0h, got %0h", want.opcode, got.opcode);
        errors++;
      end
      if (got.payload_len !== want.payload_len) begin
        $error("payload_len: expected %0d, got %0d", want.payload_len, got.payload_len);
        errors++;
      end
      if (got.payload !== want.payload) begin
        $error("payload: expected %016h, got %016h", want.payload, got.payload);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  olt_byte_if   byte_ch();
  olt_result_if result_ch();

  frame_scoreboard sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  int bytes_sent;

  opcode_length_table_framer #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (byte_ch),
    .out_result(result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && result_ch.valid && result_ch.ready)
      sb.check_result({result_ch.kind, result_ch.opcode, result_ch.payload_len,
                       result_ch.payload});
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Sender stops until every owed result has been transferred.
  task automatic drain();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Codes carry junk in the unused upper bits.
  task automatic load_random_table(input logic [BYTE_W-1:0] rc, input logic [BYTE_W-1:0] dc);
    olt_entry_t e;
    write_reg(REG_REFRESH, {5'($urandom), rc});
    write_reg(REG_DISCONNECT, {5'($urandom), dc});
    for (int i = 0; i < NUM_ENTRY_REGS; i++) begin
      e.valid = ($urandom_range(9) != 0);
      e.opcode = 8'($urandom);
      e.len = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(15))
                                       : LEN_W'($urandom_range(MAX_PAYLOAD));
      write_reg(REG_ENTRY0 + CFG_IDX_W'(i), e);
    end
    cfg_release();
  endtask

  // Mostly table opcodes with their full payload, some codes and noise.
  task automatic send_frame();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) send_byte(8'($urandom));
    else if (pick < 16) send_byte(pick[0] ? sb.refresh_code : sb.disconnect_code);
    else send_byte(sb.table_regs[$urandom_range(TABLE_ENTRIES-1)].opcode);
    while (sb.collecting) send_byte(8'($urandom));
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    int  target;
    bit  paused;
    target = bytes_sent + count;
    paused = 1'b0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (bytes_sent < target) begin
      if (!paused && bytes_sent >= target - count / 2) begin
        drain();
        paused = 1'b1;
      end
      send_frame();
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    result_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    bytes_sent = 0;
    send_idle_pct = 6;
    recv_stall_pct = 84;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset codes, empty table drops everything else
    send_byte(REFRESH_RST);
    send_byte(DISCONNECT_RST);
    send_byte(8'h00);
    drain();

    write_reg(REG_REFRESH, 13'h1F00);
    write_reg(REG_DISCONNECT, 13'h1EFF);
    write_reg(REG_ENTRY0 + 3'd0, olt_entry_t'{1'b1, 8'h01, 4'd0});
    write_reg(REG_ENTRY0 + 3'd1, olt_entry_t'{1'b1, 8'h80, 4'd8});
    write_reg(REG_ENTRY0 + 3'd2, olt_entry_t'{1'b1, 8'h01, 4'd3});  // shadowed by entry 0
    write_reg(REG_ENTRY0 + 3'd3, olt_entry_t'{1'b1, 8'hFF, 4'd9});  // same as disconnect
    write_reg(REG_ENTRY0 + 3'd4, olt_entry_t'{1'b1, 8'h7E, 4'd15}); // clipped to 8
    write_reg(REG_ENTRY0 + 3'd5, olt_entry_t'{1'b0, 8'h55, 4'd2});
    cfg_release();

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    // codes inside a payload are plain data
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFE);
    send_byte(8'hFD);
    send_byte(8'h80);
    send_byte(8'h7E);
    send_byte(8'hAA);
    send_byte(8'h7E);
    repeat (8) send_byte(8'($urandom));
    send_byte(8'h55);
    drain();

    load_random_table(8'($urandom), 8'($urandom));
    run_phase(6, 84, 160);
    load_random_table(8'($urandom), 8'($urandom));
    run_phase(84, 6, 160);
    load_random_table(8'hFF, 8'h00);
    run_phase(0, 0, 160);

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### opcode_length_table_framer.f
rtl/olt_pkg.sv
rtl/olt_byte_if.sv
rtl/olt_result_if.sv
rtl/olt_cfg_regs.sv
rtl/olt_match.sv
rtl/opcode_length_table_framer.sv
verif/opcode_length_table_framer_tb.sv
